>>> hw/rtl/sorted_set_table_macros.svh
// ----------------------------------------------------------------------------
// Sorted set table assertion macros
// Concurrent assertion wrappers, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_TABLE_MACROS_SVH
`define SORTED_SET_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define SST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// The condition must never be seen at a clock edge outside reset.
`define SST_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SST_ASSERT(lbl, prop, msg)
`define SST_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set table package
// Command codes, fixed field widths, the control bundle sent to the cells and the OR tree depth function.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CMD_W     = 2;
  localparam int KEY_IN_W  = 32;
  localparam int RANK_W    = 8;
  localparam int COUNT_W   = 9;
  localparam int ENTRY_W   = 32;
  localparam int TREE_RADIX = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_GET      = 2'd3;

  // Update strobes for the cell row, valid only in the commit cycle.
  typedef struct packed {
    logic ins;
    logic del;
  } sst_ctrl_t;

  // Number of registered levels of a radix-8 OR tree over n leaves.
  function automatic int tree_levels(input int n);
    return ($clog2(n) + 2) / 3;
  endfunction

endpackage

>>> hw/rtl/sst_cell.sv
// ----------------------------------------------------------------------------
// Sorted set table cell
// Holds one key, compares it with the request key and shifts with its
// neighbors when a key is inserted or erased.
// ----------------------------------------------------------------------------
module sst_cell #(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 9,
  parameter int IDX       = 0
) (
  input  logic                      clk_i,
  input  logic [KEY_WIDTH-1:0]      key_i,
  input  logic [CNT_W-1:0]          held_i,
  input  logic [sst_pkg::RANK_W-1:0] rank_i,
  input  sst_pkg::sst_ctrl_t        ctrl_i,
  input  logic [KEY_WIDTH-1:0]      prev_key_i,
  input  logic                      prev_lt_i,
  input  logic [KEY_WIDTH-1:0]      next_key_i,
  output logic [KEY_WIDTH-1:0]      key_o,
  output logic                      lt_o,
  output logic [KEY_WIDTH:0]        leaf_o
);

  localparam int RW = (CNT_W > sst_pkg::RANK_W) ? CNT_W : sst_pkg::RANK_W;

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 lt_q, eq_q;
  logic                 occupied;
  logic                 sel;

  assign occupied = CNT_W'(IDX) < held_i;
  assign sel      = RW'(IDX) == RW'(rank_i);

  // Since the row is sorted, the cells that are not below the request key
  // form the upper part of the row, and only they move.
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins && !lt_q) begin
      key_d = prev_lt_i ? key_i : prev_key_i;
    end else if (ctrl_i.del && !lt_q) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lt_q  <= occupied && (key_q < key_i);
    eq_q  <= occupied && (key_q == key_i);
  end

  assign key_o  = key_q;
  assign lt_o   = lt_q;
  assign leaf_o = {eq_q, sel ? key_q : {KEY_WIDTH{1'b0}}};

endmodule

>>> hw/rtl/sst_or_tree.sv
// ----------------------------------------------------------------------------
// Sorted set table OR tree
// Registered radix-8 OR reduction of the cell leaves, with every level registered.
// ----------------------------------------------------------------------------
module sst_or_tree #(
  parameter int N = 256,
  parameter int W = 33
) (
  input  logic         clk_i,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);

  localparam int LVLS = sst_pkg::tree_levels(N);
  localparam int P    = 1 << (3 * LVLS);
  localparam int NI   = (P - 1) / (sst_pkg::TREE_RADIX - 1);

  // Heap layout: node j has children 8*j+1 .. 8*j+8; indices past the
  // internal nodes are leaves, and leaves past N read as zero.
  logic [W-1:0] node_q [NI];

  for (genvar j = 0; j < NI; j++) begin : g_node
    logic [W-1:0] kid [sst_pkg::TREE_RADIX];
    for (genvar m = 0; m < sst_pkg::TREE_RADIX; m++) begin : g_kid
      localparam int C = sst_pkg::TREE_RADIX * j + 1 + m;
      if (C < NI) begin : g_int
        assign kid[m] = node_q[C];
      end else if (C - NI < N) begin : g_leaf
        assign kid[m] = leaf_i[C - NI];
      end else begin : g_pad
        assign kid[m] = '0;
      end
    end
    always_ff @(posedge clk_i) begin
      node_q[j] <= kid[0] | kid[1] | kid[2] | kid[3] | kid[4] | kid[5] | kid[6] | kid[7];
    end
  end

  assign root_o = node_q[0];

endmodule

>>> hw/rtl/sorted_set_table.sv
// ----------------------------------------------------------------------------
// Sorted set table
// Set of distinct keys kept in ascending order in a row of compare-and-shift
// cells, with insert, erase, contains and get-by-rank requests.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY distinct keys of KEY_WIDTH bits, one per
// cell, in ascending order from cell 0. A request is taken one at a time,
// only after the previous one has committed. After acceptance every cell
// registers the compare of its key with the request key, the OR tree then
// gathers the match flag and the key at the requested rank through its L
// registered radix-8 levels, L = ceil(log2(CAPACITY) / 3) (L = 3 for 256
// entries), and in the commit cycle the cells not below the request key
// shift together for an insert or erase while the result is loaded into
// the output register. Keys wider than KEY_WIDTH lose their upper bits; get
// returns a zero entry and ok low when the rank is not below the count. The
// count port shows the low nine bits of the number of keys held after the
// request. No clearing pass is needed after reset: cells at or above the
// count are never read.
// ----------------------------------------------------------------------------
`include "sorted_set_table_macros.svh"

module sorted_set_table #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sst_pkg::CMD_W-1:0]     cmd_i,
  input  logic [sst_pkg::KEY_IN_W-1:0]  key_i,
  input  logic [sst_pkg::RANK_W-1:0]    rank_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [sst_pkg::ENTRY_W-1:0]   entry_o,
  output logic [sst_pkg::COUNT_W-1:0]   count_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RW    = (CNT_W > sst_pkg::RANK_W) ? CNT_W : sst_pkg::RANK_W;
  localparam int LVLS  = sst_pkg::tree_levels(CAPACITY);
  localparam int PH_W  = $clog2(LVLS + 2);
  localparam logic [PH_W-1:0] PH_COMMIT = PH_W'(LVLS + 1);

  // Request registers, stable for the whole time a request is in flight.
  logic [sst_pkg::CMD_W-1:0]  req_cmd_q;
  logic [KEY_WIDTH-1:0]       req_key_q;
  logic [sst_pkg::RANK_W-1:0] req_rank_q;

  logic             busy_q;
  logic [PH_W-1:0]  ph_q;
  logic [CNT_W-1:0] held_q, held_d;
  logic             out_valid_q;
  logic             ok_q, ok_d;
  logic [sst_pkg::ENTRY_W-1:0] entry_q, entry_d;

  logic               in_xfer;
  logic               apply;
  logic               full;
  logic               found;
  logic               rank_ok;
  logic [KEY_WIDTH:0] root;
  sst_pkg::sst_ctrl_t cell_ctrl;

  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic                 cell_lt  [CAPACITY];
  logic [KEY_WIDTH:0]   leaf     [CAPACITY];

  // A new request is taken only when nothing is in flight and the output
  // register is free or is being emptied in the same cycle; so the output
  // register is always free again by the commit cycle.
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign apply      = busy_q && (ph_q == PH_COMMIT);

  assign full    = held_q == CNT_W'(CAPACITY);
  assign found   = root[KEY_WIDTH];
  assign rank_ok = RW'(req_rank_q) < RW'(held_q);

  // The shift strobes are qualified here so the cells act on them directly.
  always_comb begin
    cell_ctrl.ins = 1'b0;
    cell_ctrl.del = 1'b0;
    ok_d          = 1'b0;
    entry_d       = '0;
    case (req_cmd_q)
      sst_pkg::CMD_INSERT: begin
        ok_d          = !full && !found;
        cell_ctrl.ins = apply && !full && !found;
      end
      sst_pkg::CMD_ERASE: begin
        ok_d          = found;
        cell_ctrl.del = apply && found;
      end
      sst_pkg::CMD_CONTAINS: begin
        ok_d = found;
      end
      sst_pkg::CMD_GET: begin
        ok_d    = rank_ok;
        entry_d = rank_ok ? sst_pkg::ENTRY_W'(root[KEY_WIDTH-1:0]) : '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    held_d = held_q;
    if (cell_ctrl.ins) begin
      held_d = held_q + 1'b1;
    end else if (cell_ctrl.del) begin
      held_d = held_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ph_q        <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q <= held_d;
      if (in_xfer) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (apply) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        ph_q <= ph_q + 1'b1;
      end
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_cmd_q  <= cmd_i;
      req_key_q  <= KEY_WIDTH'(key_i);
      req_rank_q <= rank_i;
    end
    if (apply) begin
      ok_q    <= ok_d;
      entry_q <= entry_d;
    end
  end

  // Cell row: each cell sees the key and flag of the cell below it and the
  // key of the cell above it.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] prev_key;
    logic                 prev_lt;
    logic [KEY_WIDTH-1:0] next_key;
    if (i == 0) begin : g_first
      assign prev_key = '0;
      assign prev_lt  = 1'b1;
    end else begin : g_mid
      assign prev_key = cell_key[i-1];
      assign prev_lt  = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_body
      assign next_key = cell_key[i+1];
    end
    sst_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .key_i      (req_key_q),
      .held_i     (held_q),
      .rank_i     (req_rank_q),
      .ctrl_i     (cell_ctrl),
      .prev_key_i (prev_key),
      .prev_lt_i  (prev_lt),
      .next_key_i (next_key),
      .key_o      (cell_key[i]),
      .lt_o       (cell_lt[i]),
      .leaf_o     (leaf[i])
    );
  end

  sst_or_tree #(
    .N (CAPACITY),
    .W (KEY_WIDTH + 1)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf),
    .root_o (root)
  );

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign entry_o     = entry_q;
  assign count_o     = sst_pkg::COUNT_W'(held_q);

  // The count never runs past the capacity.
  `SST_ASSERT_NEVER(a_held_range, held_q > CNT_W'(CAPACITY), "count above capacity")
  // The output register must be free when a result is committed.
  `SST_ASSERT_NEVER(a_out_free, apply && out_valid_q, "result overwrites pending result")
  // The count changes only in a commit cycle.
  `SST_ASSERT(a_held_hold, !apply |=> $stable(held_q), "count changed outside commit")
  // A successful insert grows the count by exactly one.
  `SST_ASSERT(a_ins_grows, cell_ctrl.ins |=> held_q == CNT_W'($past(held_q) + 1'b1), "insert count")

endmodule
